[rtl/u8vr_pkg.sv]
// ----------------------------------------------------------------------------
// u8vr_pkg
// shared types and constants of the utf-8 validate and replace stream
// ----------------------------------------------------------------------------
package u8vr_pkg;

	// configuration register indexes
	localparam logic CFG_FATAL_MODE = 1'b0;
	localparam logic CFG_KEEP_BOM   = 1'b1;

	// byte classes and continuation limits
	localparam logic [7:0] ASCII_END  = 8'h80;
	localparam logic [7:0] LEAD_MIN   = 8'hC2;
	localparam logic [7:0] LEAD_END   = 8'hF5;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] CONT_LO    = 8'h80;
	localparam logic [7:0] CONT_HI    = 8'hBF;
	localparam logic [7:0] CONT_LO_E0 = 8'hA0;
	localparam logic [7:0] CONT_HI_ED = 8'h9F;
	localparam logic [7:0] CONT_LO_F0 = 8'h90;
	localparam logic [7:0] CONT_HI_F4 = 8'h8F;

	// byte order mark
	localparam logic [7:0] BOM_0 = 8'hEF;
	localparam logic [7:0] BOM_1 = 8'hBB;
	localparam logic [7:0] BOM_2 = 8'hBF;

	// replacement character u+fffd
	localparam logic [7:0] REP_0 = 8'hEF;
	localparam logic [7:0] REP_1 = 8'hBF;
	localparam logic [7:0] REP_2 = 8'hBD;

	// most results one input word can cause
	localparam int MAX_RES = 6;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// one queued output plan: the result words of one input word
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    err;   // final result is a fatal error
	} plan_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/u8vr_front.sv]
// ----------------------------------------------------------------------------
// u8vr_front
// accepts input words, tracks the partial sequence and builds output plans
// ----------------------------------------------------------------------------
module u8vr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_has,
	input  logic                in_eos,
	input  u8vr_pkg::q_status_t q_status,
	output logic                push,
	output u8vr_pkg::plan_t     push_plan
);

	logic                fatal_q, keep_bom_q;
	logic [2:0][7:0]     held_q;
	logic [1:0]          hc_q;
	logic [2:0]          nl_q;
	logic                bs_q, el_q;

	logic [2:0][7:0]     held_n;
	logic [1:0]          hc_n;
	logic [2:0]          nl_n;
	logic                bs_n, el_n;

	logic [u8vr_pkg::MAX_RES-1:0][7:0] pb;
	logic [u8vr_pkg::CNT_W-1:0]        pn;
	logic                              perr;
	logic                              do_fresh;
	logic [7:0]                        lo, hi;
	logic                              is_drop;
	logic                              accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pb       = '0;
		pn       = '0;
		perr     = 1'b0;
		do_fresh = 1'b0;
		held_n   = held_q;
		hc_n     = hc_q;
		nl_n     = nl_q;
		bs_n     = bs_q;
		el_n     = el_q;
		lo       = u8vr_pkg::CONT_LO;
		hi       = u8vr_pkg::CONT_HI;
		if (hc_q == 2'd1) begin
			case (held_q[0])
				u8vr_pkg::LEAD_E0: lo = u8vr_pkg::CONT_LO_E0;
				u8vr_pkg::LEAD_ED: hi = u8vr_pkg::CONT_HI_ED;
				u8vr_pkg::LEAD_F0: lo = u8vr_pkg::CONT_LO_F0;
				u8vr_pkg::LEAD_F4: hi = u8vr_pkg::CONT_HI_F4;
				default: ;
			endcase
		end
		is_drop = (nl_q == 3'd3) && (held_q[0] == u8vr_pkg::BOM_0)
			&& (held_q[1] == u8vr_pkg::BOM_1) && (in_byte == u8vr_pkg::BOM_2)
			&& !keep_bom_q && !bs_q;

		if (in_has && !el_q) begin
			if (hc_q == 2'd0) begin
				do_fresh = 1'b1;
			end else if (in_byte < lo || in_byte > hi) begin
				// held bytes become one replacement or error, byte is retried if not fatal
				hc_n = 2'd0;
				nl_n = 3'd0;
				bs_n = 1'b1;
				if (fatal_q) begin
					el_n  = 1'b1;
					perr  = 1'b1;
					pb[0] = 8'h00;
					pn    = u8vr_pkg::CNT_W'(1);
				end else begin
					pb[0]    = u8vr_pkg::REP_0;
					pb[1]    = u8vr_pkg::REP_1;
					pb[2]    = u8vr_pkg::REP_2;
					pn       = u8vr_pkg::CNT_W'(3);
					do_fresh = 1'b1;
				end
			end else if (({1'b0, hc_q} + 3'd1) >= nl_q) begin
				// sequence complete
				if (!is_drop) begin
					for (int i = 0; i < 3; i++) begin
						if (i < int'(hc_q)) begin
							pb[pn[u8vr_pkg::IDX_W-1:0]] = held_q[i];
							pn = pn + 1'b1;
						end
					end
					pb[pn[u8vr_pkg::IDX_W-1:0]] = in_byte;
					pn = pn + 1'b1;
				end
				bs_n = 1'b1;
				hc_n = 2'd0;
				nl_n = 3'd0;
			end else begin
				held_n[hc_q] = in_byte;
				hc_n         = hc_q + 2'd1;
			end

			if (do_fresh) begin
				if (in_byte < u8vr_pkg::ASCII_END) begin
					pb[pn[u8vr_pkg::IDX_W-1:0]] = in_byte;
					pn   = pn + 1'b1;
					bs_n = 1'b1;
				end else if (in_byte >= u8vr_pkg::LEAD_MIN && in_byte < u8vr_pkg::LEAD_END) begin
					held_n[0] = in_byte;
					hc_n      = 2'd1;
					if (in_byte < u8vr_pkg::LEAD3_MIN)
						nl_n = 3'd2;
					else if (in_byte < u8vr_pkg::LEAD4_MIN)
						nl_n = 3'd3;
					else
						nl_n = 3'd4;
				end else begin
					hc_n = 2'd0;
					nl_n = 3'd0;
					bs_n = 1'b1;
					if (fatal_q) begin
						el_n = 1'b1;
						perr = 1'b1;
						pb[pn[u8vr_pkg::IDX_W-1:0]] = 8'h00;
						pn = pn + 1'b1;
					end else begin
						pb[pn[u8vr_pkg::IDX_W-1:0]] = u8vr_pkg::REP_0;
						pn = pn + 1'b1;
						pb[pn[u8vr_pkg::IDX_W-1:0]] = u8vr_pkg::REP_1;
						pn = pn + 1'b1;
						pb[pn[u8vr_pkg::IDX_W-1:0]] = u8vr_pkg::REP_2;
						pn = pn + 1'b1;
					end
				end
			end
		end

		if (in_eos) begin
			// flush a pending partial sequence
			if (!el_n && hc_n != 2'd0) begin
				if (fatal_q) begin
					perr = 1'b1;
					pb[pn[u8vr_pkg::IDX_W-1:0]] = 8'h00;
					pn = pn + 1'b1;
				end else begin
					pb[pn[u8vr_pkg::IDX_W-1:0]] = u8vr_pkg::REP_0;
					pn = pn + 1'b1;
					pb[pn[u8vr_pkg::IDX_W-1:0]] = u8vr_pkg::REP_1;
					pn = pn + 1'b1;
					pb[pn[u8vr_pkg::IDX_W-1:0]] = u8vr_pkg::REP_2;
					pn = pn + 1'b1;
				end
			end
			hc_n = 2'd0;
			nl_n = 3'd0;
			bs_n = 1'b0;
			el_n = 1'b0;
		end
	end

	assign push            = accept && (pn != '0);
	assign push_plan.bytes = pb;
	assign push_plan.cnt   = pn;
	assign push_plan.err   = perr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fatal_q    <= 1'b0;
			keep_bom_q <= 1'b0;
			hc_q       <= 2'd0;
			nl_q       <= 3'd0;
			bs_q       <= 1'b0;
			el_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					u8vr_pkg::CFG_FATAL_MODE: fatal_q    <= cfg_data;
					u8vr_pkg::CFG_KEEP_BOM:   keep_bom_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				hc_q <= hc_n;
				nl_q <= nl_n;
				bs_q <= bs_n;
				el_q <= el_n;
			end
		end
	end

	// held bytes are payload, never read before written
	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_n;
	end

endmodule

[rtl/u8vr_queue.sv]
// ----------------------------------------------------------------------------
// u8vr_queue
// short plan queue between front and back
// ----------------------------------------------------------------------------
module u8vr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8vr_pkg::plan_t     push_plan,
	input  logic                pop,
	output u8vr_pkg::plan_t     head,
	output u8vr_pkg::q_status_t status
);

	u8vr_pkg::plan_t          mem [u8vr_pkg::QDEPTH];
	logic [u8vr_pkg::QAW-1:0] wp_q, rp_q;
	logic [u8vr_pkg::QAW:0]   cnt_q;

	assign status.full  = (cnt_q == (u8vr_pkg::QAW+1)'(u8vr_pkg::QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign head         = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= push_plan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[rtl/u8vr_back.sv]
// ----------------------------------------------------------------------------
// u8vr_back
// plays one plan out as result words, one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module u8vr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u8vr_pkg::plan_t     head,
	input  u8vr_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_err,
	output logic                out_last
);

	u8vr_pkg::plan_t            cur_q;
	logic [u8vr_pkg::IDX_W-1:0] idx_q;
	logic                       valid_q;
	logic                       take, done, load;

	assign out_valid = valid_q;
	assign out_last  = (idx_q == u8vr_pkg::IDX_W'(cur_q.cnt - 1'b1));
	assign out_err   = cur_q.err && out_last;
	assign out_byte  = out_err ? 8'h00 : cur_q.bytes[idx_q];

	assign take = valid_q && out_ready;
	assign done = take && out_last;
	assign load = !valid_q || done;
	assign pop  = load && !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

endmodule

[rtl/utf8_validate_replace_stream.sv]
// ----------------------------------------------------------------------------
// utf8_validate_replace_stream
// utf-8 validator that passes well-formed text and replaces bad subparts
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------------
// s_axis   | in  | s_tvalid/s_tready  | tdata: data_byte, tuser: has_byte,
//          |     |                    | tlast: end_of_stream
// m_axis   | out | m_tvalid/m_tready  | tdata: out_byte, tuser: error,
//          |     |                    | tlast: last result of the input word
// cfg      | in  | cfg_we             | cfg_index, cfg_data (1 bit)
//
// an input word is classified in the cycle it is accepted; its results
// (zero to six words) leave the back one per cycle unless stalled, so the input
// takes one word per cycle while output demand stays near one word per input
// the rate is set by the single output byte per cycle of the back
// a four-entry plan queue lets the input run while the output stalls;
// s_tready drops only when that queue is full
// reset clears the partial sequence, bom and error flags and both registers
//
module utf8_validate_replace_stream (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] has_byte
	input  logic       s_tlast,
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] error
	output logic       m_tlast
);

	// plan handoff between front and back
	u8vr_pkg::plan_t     push_plan, head;
	u8vr_pkg::q_status_t q_status;
	logic                push, pop;

	// front: sequence tracking, bom strip, fatal latch
	u8vr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_has    (s_tuser),
		.in_eos    (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_plan (push_plan)
	);

	// queue of pending plans
	u8vr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (push_plan),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// back: serializes each plan onto the output stream
	u8vr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_err   (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

[rtl/u8vr_checker.sv]
// ----------------------------------------------------------------------------
// u8vr_checker
// port-level checks of the utf-8 validate and replace stream
// ----------------------------------------------------------------------------
module u8vr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tuser) && $stable(m_tlast))
		else $error("output word changed under stall");

	// a fatal error is always the final result of its input word
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("error result not marked last");

	// an error result carries no byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'h00)
		else $error("error result with nonzero byte");

	// input only backs up while the output side holds a word
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid)
		else $error("input stalled with output idle");

endmodule

bind utf8_validate_replace_stream u8vr_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[bench/utf8_validate_replace_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_replace_stream_tb
// self-checking bench for the utf-8 validate and replace stream
// ----------------------------------------------------------------------------
// a queue of pending byte words feeds a clocked driver
// every accepted word runs through a local sanitizer model
// a clocked monitor checks each output word against the oldest expected word
// four register settings, short directed sequences, then random text
// random text is mostly well-formed, plus noise and truncated sequences
// both sides idle in random bursts, except in the last phase
// ----------------------------------------------------------------------------
module utf8_validate_replace_stream_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;     // cycles for the back end to go quiet

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       error;
		logic       last;
	} out_word_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = 1'b0;
	logic       cfg_data  = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;  // [7:0] data_byte
	logic       s_tuser   = 1'b0;   // [0] has_byte
	logic       s_tlast   = 1'b0;   // end_of_stream
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tuser;            // [0] error
	logic       m_tlast;            // last word caused by one input word

	in_word_t  byte_feed[$];      // words waiting for the driver
	out_word_t expected_out[$];   // predicted output words, oldest first
	out_word_t item_results[$];   // output words of the word being predicted
	in_word_t  next_word;
	out_word_t head_word;

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  send_gap       = 0;
	int  stall_left     = 0;
	bit  quiet_tail     = 1'b0;   // no idling in the last phase

	// sanitizer model state and register copies
	logic [7:0]  held[3];
	int unsigned held_cnt   = 0;
	int unsigned need_len   = 0;
	bit          bom_seen   = 1'b0;
	bit          err_latched = 1'b0;
	bit          fatal_q    = 1'b0;
	bit          keep_q     = 1'b0;

	utf8_validate_replace_stream DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// sanitizer model
	// ------------------------------------------------------------------
	function automatic void emit(input logic [7:0] b, input logic err);
		item_results.push_back('{out_byte: b, error: err, last: 1'b0});
	endfunction

	// ill-formed subpart: one u+fffd, or one error word in fatal mode
	function automatic void replace_bad();
		held_cnt = 0;
		need_len = 0;
		bom_seen = 1'b1;
		if (fatal_q) begin
			err_latched = 1'b1;
			emit(8'h00, 1'b1);
		end else begin
			emit(u8vr_pkg::REP_0, 1'b0);
			emit(u8vr_pkg::REP_1, 1'b0);
			emit(u8vr_pkg::REP_2, 1'b0);
		end
	endfunction

	function automatic void start_byte(input logic [7:0] b);
		if (b < u8vr_pkg::ASCII_END) begin
			bom_seen = 1'b1;
			emit(b, 1'b0);
		end else if (b >= u8vr_pkg::LEAD_MIN && b < u8vr_pkg::LEAD_END) begin
			held[0]  = b;
			held_cnt = 1;
			need_len = (b < u8vr_pkg::LEAD3_MIN) ? 2 : (b < u8vr_pkg::LEAD4_MIN) ? 3 : 4;
		end else begin
			replace_bad();
		end
	endfunction

	function automatic void follow_byte(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		bit         is_bom;
		lo = u8vr_pkg::CONT_LO;
		hi = u8vr_pkg::CONT_HI;
		if (held_cnt == 0) begin
			start_byte(b);
			return;
		end
		// the second byte has tighter limits after some leads
		if (held_cnt == 1) begin
			case (held[0])
				u8vr_pkg::LEAD_E0: lo = u8vr_pkg::CONT_LO_E0;
				u8vr_pkg::LEAD_ED: hi = u8vr_pkg::CONT_HI_ED;
				u8vr_pkg::LEAD_F0: lo = u8vr_pkg::CONT_LO_F0;
				u8vr_pkg::LEAD_F4: hi = u8vr_pkg::CONT_HI_F4;
				default: ;
			endcase
		end
		if (b < lo || b > hi) begin
			// drop the partial sequence, then look at this byte again unless an error is latched
			replace_bad();
			if (!err_latched)
				start_byte(b);
			return;
		end
		if (held_cnt + 1 >= need_len) begin
			is_bom = need_len == 3 && held[0] == u8vr_pkg::BOM_0
				&& held[1] == u8vr_pkg::BOM_1 && b == u8vr_pkg::BOM_2;
			if (!(is_bom && !keep_q && !bom_seen)) begin
				for (int i = 0; i < held_cnt; i++)
					emit(held[i], 1'b0);
				emit(b, 1'b0);
			end
			bom_seen = 1'b1;
			held_cnt = 0;
			need_len = 0;
			return;
		end
		held[held_cnt] = b;
		held_cnt++;
	endfunction

	// predict the output words of one accepted input word
	function automatic void sanitize_item(input in_word_t w);
		item_results.delete();
		if (w.has_byte && !err_latched)
			follow_byte(w.data_byte);
		if (w.end_of_stream) begin
			if (!err_latched && held_cnt != 0)
				replace_bad();
			held_cnt    = 0;
			need_len    = 0;
			bom_seen    = 1'b0;
			err_latched = 1'b0;
		end
		if (item_results.size() > 0)
			item_results[item_results.size()-1].last = 1'b1;
		foreach (item_results[i])
			expected_out.push_back(item_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// driver: takes words from byte_feed, idles in short bursts
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				sanitize_item('{data_byte: s_tdata, has_byte: s_tuser, end_of_stream: s_tlast});
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (byte_feed.size() > 0) begin
					if (!quiet_tail && $urandom_range(0, 6) == 0) begin
						// idle gap of random length
						send_gap = $urandom_range(0, 3);
						s_tvalid <= 1'b0;
					end else begin
						next_word = byte_feed.pop_front();
						s_tdata  <= next_word.data_byte;
						s_tuser  <= next_word.has_byte;
						s_tlast  <= next_word.end_of_stream;
						s_tvalid <= 1'b1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: stalls in short bursts, checks every accepted word
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					$error("word with nothing expected: out_byte %h error %b last %b",
						m_tdata, m_tuser, m_tlast);
					mismatch_count++;
				end else begin
					head_word = expected_out.pop_front();
					if (m_tdata !== head_word.out_byte) begin
						$error("out_byte: expected %h, got %h", head_word.out_byte, m_tdata);
						mismatch_count++;
					end
					if (m_tuser !== head_word.error) begin
						$error("error: expected %b, got %b", head_word.error, m_tuser);
						mismatch_count++;
					end
					if (m_tlast !== head_word.last) begin
						$error("last: expected %b, got %b", head_word.last, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				// stall of random length
				stall_left = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void push_item(input logic [7:0] b, input logic has, input logic eos);
		byte_feed.push_back('{data_byte: b, has_byte: has, end_of_stream: eos});
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		push_item(b, 1'b1, 1'b0);
	endfunction

	// random text: mostly well-formed sequences, some truncated ones, noise,
	// byte order marks, stream ends and bare flush words
	function automatic void push_text(input int unsigned count);
		int unsigned added;
		int unsigned pick;
		int unsigned len;
		int unsigned keep_n;
		logic [7:0]  lead;
		logic [7:0]  lo;
		logic [7:0]  hi;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 24) begin
				push_byte(8'($urandom_range(0, 127)));
				added++;
			end else if (pick < 70) begin
				len = $urandom_range(2, 4);
				if (len == 2)
					lead = 8'($urandom_range(u8vr_pkg::LEAD_MIN, u8vr_pkg::LEAD3_MIN - 1));
				else if (len == 3)
					lead = 8'($urandom_range(u8vr_pkg::LEAD3_MIN, u8vr_pkg::LEAD4_MIN - 1));
				else
					lead = 8'($urandom_range(u8vr_pkg::LEAD4_MIN, u8vr_pkg::LEAD_END - 1));
				lo = u8vr_pkg::CONT_LO;
				hi = u8vr_pkg::CONT_HI;
				case (lead)
					u8vr_pkg::LEAD_E0: lo = u8vr_pkg::CONT_LO_E0;
					u8vr_pkg::LEAD_ED: hi = u8vr_pkg::CONT_HI_ED;
					u8vr_pkg::LEAD_F0: lo = u8vr_pkg::CONT_LO_F0;
					u8vr_pkg::LEAD_F4: hi = u8vr_pkg::CONT_HI_F4;
					default: ;
				endcase
				// about one in six is cut short
				keep_n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : len;
				push_byte(lead);
				if (keep_n > 1)
					push_byte(8'($urandom_range(lo, hi)));
				for (int k = 2; k < keep_n; k++)
					push_byte(8'($urandom_range(u8vr_pkg::CONT_LO, u8vr_pkg::CONT_HI)));
				added += keep_n;
			end else if (pick < 74) begin
				push_byte(u8vr_pkg::BOM_0);
				push_byte(u8vr_pkg::BOM_1);
				push_byte(u8vr_pkg::BOM_2);
				added += 3;
			end else if (pick < 88) begin
				push_byte(8'($urandom_range(0, 255)));
				added++;
			end else if (pick < 95) begin
				push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				added++;
			end else begin
				// a bare word with no byte; ignored unless it ends the stream
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
				if (byte_feed[byte_feed.size()-1].end_of_stream)
					added++;
			end
		end
	endfunction

	// fatal mode drops bytes until the stream ends, so end streams often
	function automatic void push_fatal_text(input int unsigned chunks);
		for (int c = 0; c < chunks; c++) begin
			push_text(6);
			push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end
	endfunction

	// sender holds off until every expected word has come back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (byte_feed.size() != 0 || s_tvalid || expected_out.size() != 0);
		// a word that only extends a partial sequence has no output word
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input bit fatal, input bit keep);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= u8vr_pkg::CFG_FATAL_MODE;
		cfg_data  <= fatal;
		@(posedge clk);
		cfg_index <= u8vr_pkg::CFG_KEEP_BOM;
		cfg_data  <= keep;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fatal_q = fatal;
		keep_q  = keep;
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// replacement mode, mark stripped
		set_mode(1'b0, 1'b0);
		push_byte(u8vr_pkg::BOM_0);        // leading mark, dropped
		push_byte(u8vr_pkg::BOM_1);
		push_byte(u8vr_pkg::BOM_2);
		push_byte(8'h00);
		push_byte(8'h7F);
		push_byte(u8vr_pkg::LEAD_MIN);     // smallest two-byte form
		push_byte(u8vr_pkg::CONT_LO);
		push_byte(u8vr_pkg::LEAD_F4);      // u+10ffff
		push_byte(u8vr_pkg::CONT_HI_F4);
		push_byte(u8vr_pkg::CONT_HI);
		push_byte(u8vr_pkg::CONT_HI);
		push_byte(8'hC0);                  // never a lead
		push_byte(8'hFF);
		push_byte(u8vr_pkg::LEAD_E0);      // overlong three-byte form
		push_byte(u8vr_pkg::CONT_LO);
		push_byte(u8vr_pkg::LEAD_ED);      // surrogate
		push_byte(u8vr_pkg::CONT_LO_E0);
		push_byte(8'hE2);                  // truncated, then ascii
		push_byte(8'h82);
		push_byte(8'h41);
		push_item(8'hE2, 1'b1, 1'b1);      // stream ends on a pending lead
		push_item(8'hA5, 1'b0, 1'b0);      // no byte, no end: ignored
		push_item(8'h5A, 1'b0, 1'b1);      // bare end of stream
		wait_drained();

		// fatal mode, mark kept
		set_mode(1'b1, 1'b1);
		push_byte(u8vr_pkg::BOM_0);
		push_byte(u8vr_pkg::BOM_1);
		push_byte(u8vr_pkg::BOM_2);
		push_byte(8'h80);                  // stray continuation raises the error
		push_byte(8'h41);                  // dropped after the error
		push_item(8'h00, 1'b0, 1'b1);      // end clears the latched error
		push_fatal_text(3);
		wait_drained();

		set_mode(1'b0, 1'b1);
		push_text(16);
		wait_drained();

		set_mode(1'b1, 1'b0);
		push_fatal_text(3);
		wait_drained();

		// last phase at full rate on both sides
		quiet_tail = 1'b1;
		set_mode(1'b0, 1'b0);
		push_text(16);
		push_item(8'h00, 1'b0, 1'b1);
		wait_drained();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
